// ===== hdl/rgb_to_hsv_8bit_top_macros.svh =====
// assertion macros for the rgb to hsv converter
`ifndef RGB_TO_HSV_8BIT_TOP_MACROS_SVH
`define RGB_TO_HSV_8BIT_TOP_MACROS_SVH

// same-cycle implication
`define R2H_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define R2H_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/r2h_pkg.sv =====
// types and constants shared by the rgb to hsv converter
package r2h_pkg;

  localparam int PixW  = 8;
  localparam int QuotW = 8;
  localparam int NumW  = 2 * PixW;

  localparam logic [PixW-1:0] HueBaseRed   = 8'd0;
  localparam logic [PixW-1:0] HueBaseGreen = 8'd85;
  localparam logic [PixW-1:0] HueBaseBlue  = 8'd171;
  localparam logic [PixW-1:0] HueStep      = 8'd43;
  localparam logic [PixW-1:0] FullScale    = 8'd255;

  typedef struct packed {
    logic [NumW-1:0]  sat_rem;
    logic [NumW-1:0]  hue_rem;
    logic [QuotW-1:0] sat_q;
    logic [QuotW-1:0] hue_q;
    logic [PixW-1:0]  vmax;
    logic [PixW-1:0]  delta;
    logic [PixW-1:0]  base;
    logic             neg;
  } r2h_work_t;

endpackage

// ===== hdl/r2h_if.sv =====
// stream interfaces for rgb words and hsv words
interface r2h_rgb_if;
  import r2h_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface r2h_hsv_if;
  import r2h_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] hue;
  logic [PixW-1:0] saturation;
  logic [PixW-1:0] brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== hdl/rgb_to_hsv_8bit_top.sv =====
// rgb to hsv converter top level: front stages, divider pipeline, output word
//
//  port    dir   word                               handshake
//  pix_i   in    red, green, blue                   valid / ready
//  hsv_o   out   hue, saturation, brightness        valid / ready
//
// one word per clock unless stalled; a word passes the stages below in order
// two front stages, eight one-bit divider stages, one output stage
// the whole pipeline moves on one enable: it advances when the output
// register is empty or taken, so a stall holds every stage in place
// reset clears the valid bits only
module rgb_to_hsv_8bit_top (
  input logic clk_i,
  input logic rst_ni,
  r2h_rgb_if.sink   pix_i,
  r2h_hsv_if.source hsv_o
);
  import r2h_pkg::*;

  `include "rgb_to_hsv_8bit_top_macros.svh"

  logic                  en;
  logic                  valid_s [QuotW+1];
  r2h_work_t             work_s  [QuotW+1];
  logic                  out_valid_q;
  logic [PixW-1:0]       hue_d, sat_d, hue_q, sat_q, bri_q;
  r2h_work_t             last;

  assign en          = !out_valid_q || hsv_o.ready;
  assign pix_i.ready = en;

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .valid_o (valid_s[0]),
    .work_o  (work_s[0])
  );

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    r2h_div_stage #(
      .Shift (QuotW - 1 - k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[k]),
      .work_i  (work_s[k]),
      .valid_o (valid_s[k+1]),
      .work_o  (work_s[k+1])
    );
  end

  assign last = work_s[QuotW];

  // gray or black pixel gives zero hue and saturation
  always_comb begin
    if (last.delta == '0) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = last.neg ? (last.base - last.hue_q) : (last.base + last.hue_q);
      sat_d = last.sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= last.vmax;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;

  `R2H_ASSERT_NOW(a_black_zero, hsv_o.valid && hsv_o.brightness == '0,
    hsv_o.saturation == '0 && hsv_o.hue == '0, "black word with nonzero hue or saturation")
  `R2H_ASSERT_NOW(a_gray_hue, hsv_o.valid && hsv_o.saturation == '0,
    hsv_o.hue == '0, "zero saturation with nonzero hue")
  `R2H_ASSERT_NOW(a_out_source, hsv_o.valid && !$past(hsv_o.valid),
    $past(valid_s[QuotW]), "output word appeared with no word in the last stage")
  `R2H_ASSERT_NEXT(a_stall_hold, !en && valid_s[QuotW],
    valid_s[QuotW], "divider word lost during stall")

endmodule

// ===== hdl/r2h_front.sv =====
// front stages: max, min, channel select, delta and dividend products
module r2h_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [r2h_pkg::PixW-1:0] red_i,
  input  logic [r2h_pkg::PixW-1:0] green_i,
  input  logic [r2h_pkg::PixW-1:0] blue_i,
  output logic                     valid_o,
  output r2h_pkg::r2h_work_t       work_o
);
  import r2h_pkg::*;

  logic            a_valid_q, b_valid_q;
  logic [PixW-1:0] vmax_d, vmin_d, opa_d, opb_d, base_d;
  logic [PixW-1:0] vmax_q, vmin_q, opa_q, opb_q, base_q;
  logic [PixW-1:0] delta, mag;
  logic            neg;
  r2h_work_t       work_d, work_q;

  // first stage: pick the largest channel, red then green then blue on ties
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      vmax_d = red_i;
      opa_d  = green_i;
      opb_d  = blue_i;
      base_d = HueBaseRed;
    end else if (green_i >= blue_i) begin
      vmax_d = green_i;
      opa_d  = blue_i;
      opb_d  = red_i;
      base_d = HueBaseGreen;
    end else begin
      vmax_d = blue_i;
      opa_d  = red_i;
      opb_d  = green_i;
      base_d = HueBaseBlue;
    end
    vmin_d = red_i;
    if (green_i < vmin_d) vmin_d = green_i;
    if (blue_i < vmin_d) vmin_d = blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vmax_q <= vmax_d;
      vmin_q <= vmin_d;
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      base_q <= base_d;
      work_q <= work_d;
    end
  end

  // second stage: delta, signed difference and both dividends
  always_comb begin
    delta = vmax_q - vmin_q;
    neg   = opa_q < opb_q;
    mag   = neg ? (opb_q - opa_q) : (opa_q - opb_q);
    work_d.sat_rem = NumW'(FullScale) * NumW'(delta);
    work_d.hue_rem = NumW'(HueStep) * NumW'(mag);
    work_d.sat_q   = '0;
    work_d.hue_q   = '0;
    work_d.vmax    = vmax_q;
    work_d.delta   = delta;
    work_d.base    = base_q;
    work_d.neg     = neg;
  end

  assign valid_o = b_valid_q;
  assign work_o  = work_q;

endmodule

// ===== hdl/r2h_div_stage.sv =====
// one restoring division step for both quotients
module r2h_div_stage #(
  parameter int Shift = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  r2h_pkg::r2h_work_t work_i,
  output logic               valid_o,
  output r2h_pkg::r2h_work_t work_o
);
  import r2h_pkg::*;

  logic            valid_q;
  logic [NumW-1:0] sat_trial, hue_trial;
  logic            sat_fit, hue_fit;
  r2h_work_t       work_d, work_q;

  always_comb begin
    sat_trial = NumW'(work_i.vmax) << Shift;
    hue_trial = NumW'(work_i.delta) << Shift;
    sat_fit   = work_i.sat_rem >= sat_trial;
    hue_fit   = work_i.hue_rem >= hue_trial;
    work_d    = work_i;
    if (sat_fit) work_d.sat_rem = work_i.sat_rem - sat_trial;
    if (hue_fit) work_d.hue_rem = work_i.hue_rem - hue_trial;
    work_d.sat_q[Shift] = sat_fit;
    work_d.hue_q[Shift] = hue_fit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) work_q <= work_d;
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule
